// ===== design/triangle_geometry_factors_defines.svh =====
// assertion macros for the triangle geometry factors block
// expects signals named clock and reset in the including module
`ifndef TRIANGLE_GEOMETRY_FACTORS_DEFINES_SVH
`define TRIANGLE_GEOMETRY_FACTORS_DEFINES_SVH

// condition implies consequence in the same cycle
`define TGF_ASSERT_IMPL(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tgf assertion failed");

// condition implies consequence after the delay given by n
`define TGF_ASSERT_DELAY(name, pre, n, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> ##(n) (post)) \
      else $error("tgf delayed assertion failed");

`endif

// ===== design/tgf_pkg.sv =====
// shared types, widths and helpers for the triangle geometry factors pipeline
// no dependencies
package tgf_pkg;

   localparam int VERT_W       = 31;
   localparam int DIFF_W       = 32;
   localparam int PROD_W       = 64;
   localparam int SUM_W        = 64;
   localparam int DET_W        = 63;
   localparam int DMAG_W       = 62;
   localparam int ROOT_W       = 32;
   localparam int REM_W        = 34;
   localparam int SQRT_STAGES  = 32;
   localparam int NUM_W        = 32;
   localparam int DEN_W        = 62;
   localparam int QUO_W        = 31;
   localparam int DIV_STAGES   = QUO_W + 1;
   localparam int FRONT_STAGES = 4;
   localparam int NORM_FRAC    = 30;
   localparam int OUT_W        = 32;
   localparam int HALF_W       = 31;

   localparam logic [1:0] EDGE_V1_V2 = 2'd0;
   localparam logic [1:0] EDGE_V2_V0 = 2'd1;
   localparam logic [1:0] EDGE_V0_V1 = 2'd2;

   localparam logic [OUT_W-1:0] INV_MAX  = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] INV_MIN  = 32'h8000_0000;
   localparam logic [QUO_W-1:0] NORM_ONE = 31'h4000_0000;

   typedef struct packed {
      logic signed [DIFF_W-1:0] a;
      logic signed [DIFF_W-1:0] b;
      logic signed [DIFF_W-1:0] c;
      logic signed [DIFF_W-1:0] d;
      logic signed [DIFF_W-1:0] ex;
      logic signed [DIFF_W-1:0] ey;
   } diff_type;

   typedef struct packed {
      diff_type           geo;
      logic [DMAG_W-1:0]  det_mag;
      logic               dneg;
      logic               degen;
   } pre_type;

   typedef struct packed {
      logic [DMAG_W-1:0]  det_mag;
      logic               dneg;
      logic               degen;
      logic [ROOT_W-1:0]  root;
      logic [3:0]         inv_neg;
      logic [1:0]         nrm_neg;
   } post_type;

   function automatic logic [NUM_W-1:0] mag32(input logic signed [DIFF_W-1:0] x);
      logic [NUM_W-1:0] u;
      u = NUM_W'(x);
      mag32 = x[DIFF_W-1] ? ({NUM_W{1'b0}} - u) : u;
   endfunction

   function automatic logic [OUT_W-1:0] inv_pack(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
      logic [OUT_W-1:0] m;
      m = {1'b0, q};
      if (ovf) begin
         inv_pack = neg ? INV_MIN : INV_MAX;
      end else begin
         inv_pack = neg ? ({OUT_W{1'b0}} - m) : m;
      end
   endfunction

   function automatic logic [OUT_W-1:0] nrm_pack(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
      logic [QUO_W-1:0] qc;
      logic [OUT_W-1:0] m;
      qc = (ovf || (q > NORM_ONE)) ? NORM_ONE : q;
      m = {1'b0, qc};
      nrm_pack = neg ? ({OUT_W{1'b0}} - m) : m;
   endfunction

endpackage

// ===== design/tgf_front.sv =====
// front end: vertex differences, products, determinant magnitude, squared edge length
// depends on tgf_pkg
module tgf_front import tgf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [VERT_W-1:0] v0x,
   input  logic signed [VERT_W-1:0] v0y,
   input  logic signed [VERT_W-1:0] v1x,
   input  logic signed [VERT_W-1:0] v1y,
   input  logic signed [VERT_W-1:0] v2x,
   input  logic signed [VERT_W-1:0] v2y,
   input  logic [1:0]               edge_sel,
   output logic                     out_valid,
   output logic [SUM_W-1:0]         out_sq,
   output pre_type                  out_pre
);

   typedef struct packed {
      diff_type                 geo;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
      logic signed [PROD_W-1:0] sx;
      logic signed [PROD_W-1:0] sy;
   } prod_type;

   typedef struct packed {
      diff_type                 geo;
      logic signed [PROD_W:0]   diff;
      logic [SUM_W-1:0]         sq;
   } sum_type;

   logic [3:0]       valid_ff;
   diff_type         s1_ff, s1_in;
   prod_type         s2_ff, s2_in;
   sum_type          s3_ff, s3_in;
   pre_type          s4_ff, s4_in;
   logic [SUM_W-1:0] sq4_ff;
   logic [PROD_W:0]  mag;

   logic signed [DIFF_W-1:0] x0, y0, x1, y1, x2, y2;

   always_comb begin
      x0 = {v0x[VERT_W-1], v0x};
      y0 = {v0y[VERT_W-1], v0y};
      x1 = {v1x[VERT_W-1], v1x};
      y1 = {v1y[VERT_W-1], v1y};
      x2 = {v2x[VERT_W-1], v2x};
      y2 = {v2y[VERT_W-1], v2y};
      s1_in.a = x1 - x0;
      s1_in.b = x2 - x0;
      s1_in.c = y1 - y0;
      s1_in.d = y2 - y0;
      case (edge_sel)
         EDGE_V1_V2: begin
            s1_in.ex = x2 - x1;
            s1_in.ey = y2 - y1;
         end
         EDGE_V2_V0: begin
            s1_in.ex = x0 - x2;
            s1_in.ey = y0 - y2;
         end
         EDGE_V0_V1: begin
            s1_in.ex = x1 - x0;
            s1_in.ey = y1 - y0;
         end
         default: begin
            // unused code behaves as the first edge
            s1_in.ex = x2 - x1;
            s1_in.ey = y2 - y1;
         end
      endcase
   end

   always_comb begin
      s2_in.geo = s1_ff;
      s2_in.p1  = s1_ff.a * s1_ff.d;
      s2_in.p2  = s1_ff.b * s1_ff.c;
      s2_in.sx  = s1_ff.ex * s1_ff.ex;
      s2_in.sy  = s1_ff.ey * s1_ff.ey;
   end

   always_comb begin
      s3_in.geo  = s2_ff.geo;
      s3_in.diff = {s2_ff.p1[PROD_W-1], s2_ff.p1} - {s2_ff.p2[PROD_W-1], s2_ff.p2};
      s3_in.sq   = SUM_W'(s2_ff.sx) + SUM_W'(s2_ff.sy);
   end

   always_comb begin
      mag           = s3_ff.diff[PROD_W] ? ({(PROD_W+1){1'b0}} - s3_ff.diff) : s3_ff.diff;
      s4_in.geo     = s3_ff.geo;
      s4_in.dneg    = s3_ff.diff[PROD_W];
      s4_in.det_mag = mag[PROD_W-1:2];
      s4_in.degen   = (mag[PROD_W-1:2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      s4_ff  <= s4_in;
      sq4_ff <= s3_ff.sq;
   end

   assign out_valid = valid_ff[3];
   assign out_sq    = sq4_ff;
   assign out_pre   = s4_ff;

endmodule

// ===== design/tgf_sqrt.sv =====
// pipelined integer square root, two radicand bits per stage, with a carried payload
// depends on tgf_pkg
module tgf_sqrt import tgf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_value,
   input  pre_type           in_pre,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output pre_type           out_pre
);

   logic              valid_ff [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff   [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff  [SQRT_STAGES];
   logic [SUM_W-1:0]  value_ff [SQRT_STAGES];
   pre_type           pre_ff   [SQRT_STAGES];

   genvar k;
   for (k = 0; k < SQRT_STAGES; k++) begin : g_step
      logic              valid_src;
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SUM_W-1:0]  value_src;
      pre_type           pre_src;
      logic [REM_W+1:0]  cand;
      logic [REM_W+1:0]  trial;
      logic              fit;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [SUM_W-1:0]  value_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign value_src = in_value;
         assign pre_src   = in_pre;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign value_src = value_ff[k-1];
         assign pre_src   = pre_ff[k-1];
      end

      always_comb begin
         cand     = {rem_src, value_src[SUM_W-1 -: 2]};
         trial    = {{(REM_W-ROOT_W){1'b0}}, root_src, 2'b01};
         fit      = (cand >= trial);
         rem_in   = fit ? REM_W'(cand - trial) : cand[REM_W-1:0];
         root_in  = {root_src[ROOT_W-2:0], fit};
         value_in = {value_src[SUM_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]   <= rem_in;
         root_ff[k]  <= root_in;
         value_ff[k] <= value_in;
         pre_ff[k]   <= pre_src;
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_pre   = pre_ff[SQRT_STAGES-1];

endmodule

// ===== design/tgf_div.sv =====
// pipelined restoring divider: floor((num << SHIFT) / den), one quotient bit per stage
// flags quotients of 2^31 and above; depends on tgf_pkg
module tgf_div import tgf_pkg::*; #(
   parameter int SHIFT = 31
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   localparam int FULL_W = NUM_W + SHIFT;
   localparam int HEAD_W = FULL_W - QUO_W;

   logic [FULL_W-1:0] full;
   logic [DEN_W-1:0]  head;

   logic [DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0] low_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];
   logic             ovf_ff [DIV_STAGES];

   assign full = {num, {SHIFT{1'b0}}};
   assign head = {{(DEN_W-HEAD_W){1'b0}}, full[FULL_W-1:QUO_W]};

   // leading part at or above the divisor means the quotient needs more than QUO_W bits
   always_ff @(posedge clock) begin
      rem_ff[0] <= head;
      den_ff[0] <= den;
      low_ff[0] <= full[QUO_W-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= (head >= den);
   end

   genvar j;
   for (j = 1; j < DIV_STAGES; j++) begin : g_step
      logic [DEN_W:0]   cand;
      logic [DEN_W:0]   dext;
      logic             fit;
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         cand   = {rem_ff[j-1], low_ff[j-1][QUO_W-1]};
         dext   = {1'b0, den_ff[j-1]};
         fit    = (cand >= dext);
         rem_in = fit ? DEN_W'(cand - dext) : cand[DEN_W-1:0];
         quo_in = {quo_ff[j-1][QUO_W-2:0], fit};
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         den_ff[j] <= den_ff[j-1];
         low_ff[j] <= {low_ff[j-1][QUO_W-2:0], 1'b0};
         quo_ff[j] <= quo_in;
         ovf_ff[j] <= ovf_ff[j-1];
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];
   assign ovf = ovf_ff[DIV_STAGES-1];

endmodule

// ===== design/triangle_geometry_factors.sv =====
// triangle geometry factors: fully pipelined, one item per cycle, busy is never raised
// path from start to rsp_valid: 4 front stages (differences, 32x32 products,
// determinant), 32 square root stages and 32 divider stages, then the output register
// synchronous active-high reset clears all valid bits; payload registers are not reset
// depends on tgf_pkg, tgf_front, tgf_sqrt, tgf_div and the assertion macro header
`include "triangle_geometry_factors_defines.svh"

module triangle_geometry_factors import tgf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [VERT_W-1:0] req_vertex0_x,
   input  logic signed [VERT_W-1:0] req_vertex0_y,
   input  logic signed [VERT_W-1:0] req_vertex1_x,
   input  logic signed [VERT_W-1:0] req_vertex1_y,
   input  logic signed [VERT_W-1:0] req_vertex2_x,
   input  logic signed [VERT_W-1:0] req_vertex2_y,
   input  logic [1:0]               req_edge_index,
   output logic                     rsp_valid,
   output logic signed [DET_W-1:0]  rsp_jacobian_det,
   output logic signed [OUT_W-1:0]  rsp_inv_00,
   output logic signed [OUT_W-1:0]  rsp_inv_01,
   output logic signed [OUT_W-1:0]  rsp_inv_10,
   output logic signed [OUT_W-1:0]  rsp_inv_11,
   output logic [HALF_W-1:0]        rsp_edge_half_length,
   output logic signed [OUT_W-1:0]  rsp_normal_x,
   output logic signed [OUT_W-1:0]  rsp_normal_y,
   output logic                     rsp_degenerate
);

   // inverse entries are num * 2^(2*frac-1) / det
   localparam int INV_SHIFT = 2 * FRAC_BITS - 1;
   localparam int LATENCY   = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

   // the pipeline never stalls, so an item is taken on every start
   assign busy = 1'b0;

   // front end
   logic             fr_valid;
   logic [SUM_W-1:0] fr_sq;
   pre_type          fr_pre;

   tgf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .v0x       (req_vertex0_x),
      .v0y       (req_vertex0_y),
      .v1x       (req_vertex1_x),
      .v1y       (req_vertex1_y),
      .v2x       (req_vertex2_x),
      .v2y       (req_vertex2_y),
      .edge_sel  (req_edge_index),
      .out_valid (fr_valid),
      .out_sq    (fr_sq),
      .out_pre   (fr_pre)
   );

   // edge length root, the determinant and differences ride along
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   pre_type           sq_pre;

   tgf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_value  (fr_sq),
      .in_pre    (fr_pre),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_pre   (sq_pre)
   );

   // divider operands: magnitudes here, signs travel in the side line
   logic [NUM_W-1:0] num_00, num_01, num_10, num_11, num_nx, num_ny;
   logic [DEN_W-1:0] den_len;
   post_type         post_in;

   always_comb begin
      num_00  = mag32(sq_pre.geo.d);
      num_01  = mag32(sq_pre.geo.b);
      num_10  = mag32(sq_pre.geo.c);
      num_11  = mag32(sq_pre.geo.a);
      num_nx  = mag32(sq_pre.geo.ey);
      num_ny  = mag32(sq_pre.geo.ex);
      den_len = {{(DEN_W-ROOT_W){1'b0}}, sq_root};

      post_in.det_mag = sq_pre.det_mag;
      post_in.dneg    = sq_pre.dneg;
      post_in.degen   = sq_pre.degen;
      post_in.root    = sq_root;
      // numerators of inv_01, inv_10 and normal_y are negated differences
      post_in.inv_neg[0] = sq_pre.geo.d[DIFF_W-1] ^ sq_pre.dneg;
      post_in.inv_neg[1] = !sq_pre.geo.b[DIFF_W-1] ^ sq_pre.dneg;
      post_in.inv_neg[2] = !sq_pre.geo.c[DIFF_W-1] ^ sq_pre.dneg;
      post_in.inv_neg[3] = sq_pre.geo.a[DIFF_W-1] ^ sq_pre.dneg;
      post_in.nrm_neg[0] = sq_pre.geo.ey[DIFF_W-1] ^ sq_pre.dneg;
      post_in.nrm_neg[1] = !sq_pre.geo.ex[DIFF_W-1] ^ sq_pre.dneg;
   end

   logic [QUO_W-1:0] q_00, q_01, q_10, q_11, q_nx, q_ny;
   logic             o_00, o_01, o_10, o_11, o_nx, o_ny;

   tgf_div #(.SHIFT(INV_SHIFT)) u_div_00 (
      .clock (clock), .num (num_00), .den (sq_pre.det_mag), .quo (q_00), .ovf (o_00)
   );
   tgf_div #(.SHIFT(INV_SHIFT)) u_div_01 (
      .clock (clock), .num (num_01), .den (sq_pre.det_mag), .quo (q_01), .ovf (o_01)
   );
   tgf_div #(.SHIFT(INV_SHIFT)) u_div_10 (
      .clock (clock), .num (num_10), .den (sq_pre.det_mag), .quo (q_10), .ovf (o_10)
   );
   tgf_div #(.SHIFT(INV_SHIFT)) u_div_11 (
      .clock (clock), .num (num_11), .den (sq_pre.det_mag), .quo (q_11), .ovf (o_11)
   );
   tgf_div #(.SHIFT(NORM_FRAC)) u_div_nx (
      .clock (clock), .num (num_nx), .den (den_len), .quo (q_nx), .ovf (o_nx)
   );
   tgf_div #(.SHIFT(NORM_FRAC)) u_div_ny (
      .clock (clock), .num (num_ny), .den (den_len), .quo (q_ny), .ovf (o_ny)
   );

   // side line matched to the divider depth
   logic     line_valid_ff [DIV_STAGES];
   post_type line_ff       [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            line_valid_ff[i] <= 1'b0;
         end
      end else begin
         line_valid_ff[0] <= sq_valid;
         for (int i = 1; i < DIV_STAGES; i++) begin
            line_valid_ff[i] <= line_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      line_ff[0] <= post_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   // output stage: sign, saturate, force zero on degenerate or zero length
   post_type          tail;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DET_W-1:0]  det_ff, det_in;
   logic [OUT_W-1:0]  inv00_ff, inv00_in, inv01_ff, inv01_in;
   logic [OUT_W-1:0]  inv10_ff, inv10_in, inv11_ff, inv11_in;
   logic [OUT_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic              degen_ff, degen_in;

   always_comb begin
      tail         = line_ff[DIV_STAGES-1];
      rsp_valid_in = line_valid_ff[DIV_STAGES-1];
      det_in       = tail.dneg ? ({DET_W{1'b0}} - {1'b0, tail.det_mag})
                               : {1'b0, tail.det_mag};
      half_in      = tail.root[ROOT_W-1:1];
      degen_in     = tail.degen;
      if (tail.degen) begin
         inv00_in = '0;
         inv01_in = '0;
         inv10_in = '0;
         inv11_in = '0;
         nx_in    = '0;
         ny_in    = '0;
      end else begin
         inv00_in = inv_pack(q_00, o_00, tail.inv_neg[0]);
         inv01_in = inv_pack(q_01, o_01, tail.inv_neg[1]);
         inv10_in = inv_pack(q_10, o_10, tail.inv_neg[2]);
         inv11_in = inv_pack(q_11, o_11, tail.inv_neg[3]);
         if (tail.root == '0) begin
            nx_in = '0;
            ny_in = '0;
         end else begin
            nx_in = nrm_pack(q_nx, o_nx, tail.nrm_neg[0]);
            ny_in = nrm_pack(q_ny, o_ny, tail.nrm_neg[1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      det_ff   <= det_in;
      inv00_ff <= inv00_in;
      inv01_ff <= inv01_in;
      inv10_ff <= inv10_in;
      inv11_ff <= inv11_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      half_ff  <= half_in;
      degen_ff <= degen_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_jacobian_det     = det_ff;
   assign rsp_inv_00           = inv00_ff;
   assign rsp_inv_01           = inv01_ff;
   assign rsp_inv_10           = inv10_ff;
   assign rsp_inv_11           = inv11_ff;
   assign rsp_normal_x         = nx_ff;
   assign rsp_normal_y         = ny_ff;
   assign rsp_edge_half_length = half_ff;
   assign rsp_degenerate       = degen_ff;

   // every accepted item comes out after the fixed pipeline depth
   `TGF_ASSERT_DELAY(a_fixed_latency, start && !busy, LATENCY, rsp_valid)
   // degenerate flag tracks a zero determinant
   `TGF_ASSERT_IMPL(a_degen_det, rsp_valid, rsp_degenerate == (rsp_jacobian_det == '0))
   // degenerate items carry no inverse and no normal
   `TGF_ASSERT_IMPL(a_degen_zero, rsp_valid && rsp_degenerate, rsp_inv_00 == '0 && rsp_inv_01 == '0 && rsp_inv_10 == '0 && rsp_inv_11 == '0 && rsp_normal_x == '0 && rsp_normal_y == '0)
   // normal components stay within unit magnitude
   `TGF_ASSERT_IMPL(a_normal_bound, rsp_valid, rsp_normal_x <= 32'sh4000_0000 && rsp_normal_x >= -32'sh4000_0000 && rsp_normal_y <= 32'sh4000_0000 && rsp_normal_y >= -32'sh4000_0000)

endmodule

// ===== tb/triangle_geometry_factors_tb.sv =====
// self-checking testbench for triangle_geometry_factors: directed and random triangles
// predicts determinant, inverse, edge half length and normal; depends on tgf_pkg and the block
module triangle_geometry_factors_tb;
   import tgf_pkg::*;

   // one input item: three vertices and the edge number
   typedef struct {
      logic signed [VERT_W-1:0] vx [3];
      logic signed [VERT_W-1:0] vy [3];
      logic [1:0]               edge_num;
   } triangle_type;

   // one result item as the block presents it
   typedef struct {
      logic [DET_W-1:0]  det;
      logic [OUT_W-1:0]  inv [4];
      logic [HALF_W-1:0] half_len;
      logic [OUT_W-1:0]  nx;
      logic [OUT_W-1:0]  ny;
      logic              degen;
   } factors_type;

   localparam int LATENCY     = 69;
   localparam int STALL_LIMIT = 5000;
   localparam longint VMIN    = -64'sd1073741824;
   localparam longint VMAX    = 64'sd1073741823;
   localparam logic [63:0] QUO_CAP = 64'd1 << 33;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VERT_W-1:0] req_vertex0_x = '0, req_vertex0_y = '0;
   logic signed [VERT_W-1:0] req_vertex1_x = '0, req_vertex1_y = '0;
   logic signed [VERT_W-1:0] req_vertex2_x = '0, req_vertex2_y = '0;
   logic [1:0]               req_edge_index = EDGE_V1_V2;
   logic                     rsp_valid;
   logic signed [DET_W-1:0]  rsp_jacobian_det;
   logic signed [OUT_W-1:0]  rsp_inv_00, rsp_inv_01, rsp_inv_10, rsp_inv_11;
   logic [HALF_W-1:0]        rsp_edge_half_length;
   logic signed [OUT_W-1:0]  rsp_normal_x, rsp_normal_y;
   logic                     rsp_degenerate;

   factors_type expected_factors [$];
   int          error_count = 0;
   int          quiet_cycles = 0;
   bit          item_taken;
   int          sender_idle_pct = 0;

   always #1 clock = ~clock;

   triangle_geometry_factors u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex0_x(req_vertex0_x), .req_vertex0_y(req_vertex0_y),
      .req_vertex1_x(req_vertex1_x), .req_vertex1_y(req_vertex1_y),
      .req_vertex2_x(req_vertex2_x), .req_vertex2_y(req_vertex2_y),
      .req_edge_index(req_edge_index),
      .rsp_valid(rsp_valid), .rsp_jacobian_det(rsp_jacobian_det),
      .rsp_inv_00(rsp_inv_00), .rsp_inv_01(rsp_inv_01),
      .rsp_inv_10(rsp_inv_10), .rsp_inv_11(rsp_inv_11),
      .rsp_edge_half_length(rsp_edge_half_length),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_degenerate(rsp_degenerate)
   );

   // magnitude of a signed 64-bit value
   function automatic logic [63:0] abs64(input longint x);
      abs64 = (x < 0) ? 64'd0 - 64'(x) : 64'(x);
   endfunction

   // restoring division of (n << sh) by m, quotient held at 2^33
   function automatic logic [63:0] shifted_quotient(input logic [63:0] n, input int sh,
                                                    input logic [63:0] m);
      logic [63:0] rem, quo, nbit;
      rem = 0;
      quo = 0;
      if (m == 0) return QUO_CAP;
      for (int i = 31 + sh; i >= 0; i--) begin
         nbit = (i >= sh) ? ((n >> (i - sh)) & 64'd1) : 64'd0;
         rem = (rem << 1) | nbit;
         quo = quo << 1;
         if (rem >= m) begin
            rem = rem - m;
            quo = quo | 64'd1;
         end
         if (quo >= QUO_CAP) quo = QUO_CAP;
      end
      return quo;
   endfunction

   // floor square root of a 64-bit value
   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res, pbit;
      res = 0;
      pbit = 64'd1 << 62;
      while (pbit > v) pbit = pbit >> 2;
      while (pbit != 0) begin
         if (v >= res + pbit) begin
            v = v - (res + pbit);
            res = (res >> 1) + pbit;
         end else begin
            res = res >> 1;
         end
         pbit = pbit >> 2;
      end
      return res;
   endfunction

   // inverse entry: num * 2^31 / det, truncated, saturating to 32 bits
   function automatic logic [OUT_W-1:0] inverse_entry(input longint num, input bit det_neg,
                                                     input logic [63:0] det_mag);
      logic [63:0] q;
      bit neg;
      q = shifted_quotient(abs64(num), 31, det_mag);
      neg = (num < 0) != det_neg;
      if (q == 0) return '0;
      if (neg) return (q >= (64'd1 << 31)) ? INV_MIN : OUT_W'(64'd0 - q);
      return (q > 64'h7FFF_FFFF) ? INV_MAX : OUT_W'(q);
   endfunction

   // normal component in Q1.30, clamped to magnitude one
   function automatic logic [OUT_W-1:0] normal_comp(input longint num, input bit flip,
                                                   input logic [63:0] len);
      logic [63:0] q;
      q = shifted_quotient(abs64(num), NORM_FRAC, len);
      if (q > (64'd1 << NORM_FRAC)) q = 64'd1 << NORM_FRAC;
      if ((num < 0) != flip) q = 64'd0 - q;
      return OUT_W'(q);
   endfunction

   function automatic factors_type predict_factors(input triangle_type t);
      factors_type f;
      longint x [3], y [3];
      longint a, b, c, d, p1, p2, ex, ey;
      logic [63:0] dmag, det_mag, len;
      bit dneg;
      int pb, pe;
      for (int i = 0; i < 3; i++) begin
         x[i] = longint'(t.vx[i]);
         y[i] = longint'(t.vy[i]);
      end
      a = x[1] - x[0];
      b = x[2] - x[0];
      c = y[1] - y[0];
      d = y[2] - y[0];
      p1 = a * d;
      p2 = b * c;
      // unsigned difference avoids signed overflow near 2^63
      dneg = !(p1 >= p2);
      dmag = dneg ? 64'(p2) - 64'(p1) : 64'(p1) - 64'(p2);
      det_mag = dmag >> 2;
      f.det = DET_W'(dneg ? 64'd0 - det_mag : det_mag);
      // edge 3 falls back to v1 -> v2
      case (t.edge_num)
         EDGE_V2_V0: begin pb = 2; pe = 0; end
         EDGE_V0_V1: begin pb = 0; pe = 1; end
         default:    begin pb = 1; pe = 2; end
      endcase
      ex = x[pe] - x[pb];
      ey = y[pe] - y[pb];
      len = floor_root(64'(ex * ex) + 64'(ey * ey));
      f.half_len = HALF_W'(len >> 1);
      f.degen = (det_mag == 0);
      for (int i = 0; i < 4; i++) f.inv[i] = '0;
      f.nx = '0;
      f.ny = '0;
      if (!f.degen) begin
         f.inv[0] = inverse_entry(d, dneg, det_mag);
         f.inv[1] = inverse_entry(-b, dneg, det_mag);
         f.inv[2] = inverse_entry(-c, dneg, det_mag);
         f.inv[3] = inverse_entry(a, dneg, det_mag);
         if (len != 0) begin
            f.nx = normal_comp(ey, dneg, len);
            f.ny = normal_comp(-ex, dneg, len);
         end
      end
      return f;
   endfunction

   // present one item and hold it until the block takes it
   task automatic send_triangle(input triangle_type t);
      bit taken;
      req_vertex0_x <= t.vx[0];
      req_vertex0_y <= t.vy[0];
      req_vertex1_x <= t.vx[1];
      req_vertex1_y <= t.vy[1];
      req_vertex2_x <= t.vx[2];
      req_vertex2_y <= t.vy[2];
      req_edge_index <= t.edge_num;
      start <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      expected_factors.insert(expected_factors.size(), predict_factors(t));
      item_taken = 1'b1;
      // random sender gaps between items
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic triangle_type make_triangle(input longint x0, y0, x1, y1, x2, y2,
                                                  input logic [1:0] e);
      triangle_type t;
      t.vx[0] = VERT_W'(x0); t.vy[0] = VERT_W'(y0);
      t.vx[1] = VERT_W'(x1); t.vy[1] = VERT_W'(y1);
      t.vx[2] = VERT_W'(x2); t.vy[2] = VERT_W'(y2);
      t.edge_num = e;
      return t;
   endfunction

   // random triangle: full range, mesh-sized, collinear, or with v2 copying v0's y and the x of v0 or v1
   function automatic triangle_type random_triangle();
      triangle_type t;
      logic signed [VERT_W-1:0] cx, cy;
      int kind;
      int span;
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         t.vx[i] = VERT_W'($urandom);
         t.vy[i] = VERT_W'($urandom);
      end
      t.edge_num = 2'($urandom);
      if (kind >= 3 && kind <= 7) begin
         // local element around a random point
         span = 1 << $urandom_range(24, 2);
         cx = VERT_W'($urandom) >>> 2;
         cy = VERT_W'($urandom) >>> 2;
         for (int i = 0; i < 3; i++) begin
            t.vx[i] = cx + VERT_W'($urandom_range(span)) - VERT_W'(span / 2);
            t.vy[i] = cy + VERT_W'($urandom_range(span)) - VERT_W'(span / 2);
         end
      end else if (kind == 8) begin
         // collinear: v2 sits on the line through v0 and v1
         t.vx[1] = (t.vx[0] >>> 1) + ($signed(VERT_W'($urandom)) >>> 3);
         t.vy[1] = (t.vy[0] >>> 1) + ($signed(VERT_W'($urandom)) >>> 3);
         t.vx[0] = t.vx[0] >>> 1;
         t.vy[0] = t.vy[0] >>> 1;
         t.vx[2] = t.vx[1] + (t.vx[1] - t.vx[0]);
         t.vy[2] = t.vy[1] + (t.vy[1] - t.vy[0]);
      end else if (kind == 9) begin
         t.vx[2] = t.vx[$urandom_range(1)];
         t.vy[2] = t.vy[0];
      end
      return t;
   endfunction

   task automatic test_directed();
      // all zero: degenerate with zero edge length
      send_triangle(make_triangle(0, 0, 0, 0, 0, 0, EDGE_V1_V2));
      // unit right triangle, every edge and edge number three
      for (int e = 0; e < 4; e++)
         send_triangle(make_triangle(0, 0, 65536, 0, 0, 65536, 2'(e)));
      // clockwise orientation flips the normal
      send_triangle(make_triangle(0, 0, 0, 65536, 65536, 0, EDGE_V2_V0));
      // extremes of the coordinate range
      send_triangle(make_triangle(VMIN, VMIN, VMAX, VMIN, VMIN, VMAX, EDGE_V1_V2));
      send_triangle(make_triangle(VMAX, VMAX, VMIN, VMAX, VMAX, VMIN, EDGE_V2_V0));
      send_triangle(make_triangle(VMIN, VMAX, VMAX, VMIN, VMAX, VMAX, EDGE_V0_V1));
      send_triangle(make_triangle(VMAX, VMIN, VMIN, VMAX, VMIN, VMIN, 2'd3));
      // tiny determinant that truncates to zero
      send_triangle(make_triangle(0, 0, 1, 0, 0, 1, EDGE_V1_V2));
      send_triangle(make_triangle(0, 0, 1, 1, 2, 3, EDGE_V0_V1));
      // smallest nonzero determinant, then a large one: saturating inverse
      send_triangle(make_triangle(0, 0, 2, 0, 0, 2, EDGE_V1_V2));
      send_triangle(make_triangle(0, 0, 0, 2, 2, 0, EDGE_V2_V0));
      send_triangle(make_triangle(VMIN, 0, VMAX, 2, VMAX, 4, EDGE_V1_V2));
      // collinear and repeated vertices
      send_triangle(make_triangle(-100, -100, 0, 0, 100, 100, EDGE_V2_V0));
      send_triangle(make_triangle(5000, 7000, 5000, 7000, -3000, 9000, EDGE_V0_V1));
      // thin sliver with long edges
      send_triangle(make_triangle(VMIN, 0, VMAX, 0, 0, 4, EDGE_V0_V1));
      send_triangle(make_triangle(0, VMIN, 4, 0, 0, VMAX, EDGE_V2_V0));
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) send_triangle(random_triangle());
   endtask

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         $display("%0t mismatch %s: expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   // result is stable mid-cycle, so it is checked on the falling edge
   always @(negedge clock) begin
      factors_type f;
      if (!reset && rsp_valid) begin
         if (expected_factors.size() == 0) begin
            error_count++;
            $display("%0t unexpected result item, det %h", $time, rsp_jacobian_det);
         end else begin
            f = expected_factors.pop_front();
            compare_field("jacobian_det", 64'(f.det), 64'($unsigned(rsp_jacobian_det)));
            compare_field("inv_00", 64'(f.inv[0]), 64'($unsigned(rsp_inv_00)));
            compare_field("inv_01", 64'(f.inv[1]), 64'($unsigned(rsp_inv_01)));
            compare_field("inv_10", 64'(f.inv[2]), 64'($unsigned(rsp_inv_10)));
            compare_field("inv_11", 64'(f.inv[3]), 64'($unsigned(rsp_inv_11)));
            compare_field("edge_half_length", 64'(f.half_len), 64'(rsp_edge_half_length));
            compare_field("normal_x", 64'(f.nx), 64'($unsigned(rsp_normal_x)));
            compare_field("normal_y", 64'(f.ny), 64'($unsigned(rsp_normal_y)));
            compare_field("degenerate", 64'(f.degen), 64'(rsp_degenerate));
         end
      end
   end

   // watchdog: cycles with neither an item taken nor a result seen
   always @(posedge clock) begin
      if (reset || item_taken || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      item_taken = 1'b0;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("triangle_geometry_factors_tb: errors");
         $finish;
      end
   end

   initial begin
      item_taken = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      // phases: back to back, sparse sender, moderate sender, back to back again
      sender_idle_pct = 0;
      test_random(225);
      sender_idle_pct = 84;
      test_random(225);
      sender_idle_pct = 36;
      test_random(225);
      sender_idle_pct = 0;
      test_random(225);
      start <= 1'b0;
      while (expected_factors.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("triangle_geometry_factors_tb: clean");
      end else begin
         $display("triangle_geometry_factors_tb: errors");
      end
      $finish;
   end

endmodule
